// File: hw/rtl/spimf_pkg.sv
// spimf_pkg: shared types and constants for the spi master register block
// used by spi_master_fifo_registers_core and its checker, no dependencies
`timescale 1ns / 1ps

package spimf_pkg;

  localparam int FIFO_DEPTH = 8;
  localparam int IRQ_LEVEL  = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;

  // request kinds carried on the input tuser
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_REPLY = 2'd2;

  // register offsets
  localparam logic [11:0] OFF_CR0   = 12'h000;
  localparam logic [11:0] OFF_CR1   = 12'h004;
  localparam logic [11:0] OFF_DATA  = 12'h008;
  localparam logic [11:0] OFF_STAT  = 12'h00c;
  localparam logic [11:0] OFF_PRESC = 12'h010;
  localparam logic [11:0] OFF_IMSC  = 12'h014;
  localparam logic [11:0] OFF_RIS   = 12'h018;
  localparam logic [11:0] OFF_MIS   = 12'h01c;
  localparam logic [11:0] OFF_ICR   = 12'h020;
  localparam logic [11:0] OFF_ID    = 12'hfe0;

  localparam int CR1_LOOP_BIT   = 0;
  localparam int CR1_ENABLE_BIT = 1;

  localparam logic [7:0] ID_BYTES [8] = '{8'h22, 8'h10, 8'h04, 8'h00,
                                          8'h0d, 8'hf0, 8'h05, 8'hb1};

  // stream payload layout
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUMP,
    ST_REFRESH,
    ST_FINISH
  } seq_state_t;

endpackage

// File: hw/rtl/spi_master_fifo_registers_core.sv
// spi_master_fifo_registers_core: register-mapped spi master with tx and rx fifos
// depends on spimf_pkg
`timescale 1ns / 1ps
//
// channel  | direction | tdata (low bit up)                           | tuser
// s_axis   | in        | offset[11:0] write_data[43:12] slave_data[59:44] | action[1:0]
// m_axis   | out       | read_data[31:0] irq[32] send_word[48:33]         | send_valid[0]
//
// a plain register access passes exec and the output load in finish; an interrupt mask
// write adds a refresh step, and a data read (rx not empty), a data write (tx not full), a
// cr1 write and a slave reply (word in flight) add pump and refresh steps; a loopback drain
// stays in pump as words move (up to FIFO_DEPTH), on the single fifo pointer/count sequencer
// s_axis_tready is high only while the sequencer is idle, from the cycle after the output load
// a waiting result sits in the output register; the next request may already be taken and
// then holds in finish until that result is accepted
// rst is synchronous and active high; fifo contents have no reset

module spi_master_fifo_registers_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // offset, write_data, slave_data, zero pad
  input  logic [spimf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // action
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // read_data, irq, send_word, zero pad
  output logic [spimf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // send_valid
  output logic [0:0]                         m_axis_tuser
);
  import spimf_pkg::*;

  seq_state_t state, state_next;

  // request held for the sequencer
  logic [1:0]  act;
  logic [11:0] off;
  logic [31:0] wdat;
  logic [15:0] sdat;

  logic [31:0] ctrl_zero;
  logic [31:0] ctrl_one;
  logic [15:0] word_mask;
  logic [7:0]  prescale;
  logic [3:0]  raw_irq;
  logic [31:0] irq_enable;
  logic [PTR_W-1:0] tx_head, rx_head;
  logic [CNT_W-1:0] tx_count, rx_count;
  logic [15:0] tx_store [FIFO_DEPTH];
  logic [15:0] rx_store [FIFO_DEPTH];
  logic        in_flight;
  logic        irq_level;

  logic [31:0] rd_hold;
  logic        send_hold;
  logic [15:0] word_hold;

  logic        out_valid;
  logic [31:0] out_rd;
  logic        out_irq;
  logic        out_send;
  logic [15:0] out_word;

  logic [PTR_W-1:0] tx_oldest, rx_oldest;
  logic        tx_empty, tx_full, rx_empty, rx_full;
  logic [4:0]  status;
  logic [3:0]  raw_next;
  logic        pump_go;
  logic        exec_pump, exec_refresh;
  logic        out_load;
  logic [31:0] rd_val;

  function automatic logic [PTR_W-1:0] oldest(input logic [PTR_W-1:0] head,
                                              input logic [CNT_W-1:0] cnt);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(FIFO_DEPTH) - SUM_W'(cnt);
    if (sum >= SUM_W'(FIFO_DEPTH)) begin
      sum = sum - SUM_W'(FIFO_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // data size field n keeps n+1 low bits
  function automatic logic [15:0] size_mask(input logic [3:0] n);
    logic [15:0] m;
    for (int i = 0; i < 16; i++) begin
      m[i] = (4'(i) <= n);
    end
    return m;
  endfunction

  assign tx_oldest = oldest(tx_head, tx_count);
  assign rx_oldest = oldest(rx_head, rx_count);
  assign tx_empty  = (tx_count == '0);
  assign tx_full   = (tx_count == CNT_W'(FIFO_DEPTH));
  assign rx_empty  = (rx_count == '0);
  assign rx_full   = (rx_count == CNT_W'(FIFO_DEPTH));
  assign status    = {!tx_empty, rx_full, !rx_empty, !tx_full, tx_empty};
  assign raw_next  = {tx_count <= CNT_W'(IRQ_LEVEL), rx_count >= CNT_W'(IRQ_LEVEL),
                      !rx_empty && tx_empty, 1'b0};
  assign pump_go   = ctrl_one[CR1_ENABLE_BIT] && !in_flight && !tx_empty && !rx_full;
  assign out_load  = (state == ST_FINISH) && (!out_valid || m_axis_tready);

  // decode of what follows the register access
  always_comb begin
    exec_pump    = 1'b0;
    exec_refresh = 1'b0;
    case (act)
      ACT_READ: begin
        exec_pump = (off == OFF_DATA) && !rx_empty;
      end
      ACT_WRITE: begin
        exec_pump    = (off == OFF_CR1) || ((off == OFF_DATA) && !tx_full);
        exec_refresh = (off == OFF_IMSC);
      end
      ACT_REPLY: begin
        exec_pump = in_flight;
      end
      default: begin
        exec_pump = 1'b0;
      end
    endcase
  end

  // read value of the held request, zero for anything but a bus read
  always_comb begin
    rd_val = '0;
    if (act == ACT_READ) begin
      if (off >= OFF_ID) begin
        rd_val = {24'b0, ID_BYTES[off[4:2]]};
      end else begin
        case (off)
          OFF_CR0:   rd_val = ctrl_zero;
          OFF_CR1:   rd_val = ctrl_one;
          OFF_DATA:  rd_val = rx_empty ? 32'b0 : {16'b0, rx_store[rx_oldest]};
          OFF_STAT:  rd_val = {27'b0, status};
          OFF_PRESC: rd_val = {24'b0, prescale};
          OFF_IMSC:  rd_val = irq_enable;
          OFF_RIS:   rd_val = {28'b0, raw_irq};
          OFF_MIS:   rd_val = {28'b0, raw_irq & irq_enable[3:0]};
          default:   rd_val = '0;
        endcase
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_pump) state_next = ST_PUMP;
        else if (exec_refresh) state_next = ST_REFRESH;
        else state_next = ST_FINISH;
      end
      ST_PUMP: begin
        // loopback stays here while words can move
        if (!(pump_go && ctrl_one[CR1_LOOP_BIT])) state_next = ST_REFRESH;
      end
      ST_REFRESH: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_word, out_irq, out_rd};
  assign m_axis_tuser  = out_send;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ctrl_zero  <= '0;
      ctrl_one   <= '0;
      word_mask  <= '0;
      prescale   <= '0;
      raw_irq    <= 4'h8;
      irq_enable <= '0;
      tx_head    <= '0;
      rx_head    <= '0;
      tx_count   <= '0;
      rx_count   <= '0;
      in_flight  <= 1'b0;
      irq_level  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            act  <= s_axis_tuser;
            off  <= s_axis_tdata[11:0];
            wdat <= s_axis_tdata[43:12];
            sdat <= s_axis_tdata[59:44];
          end
        end
        ST_EXEC: begin
          rd_hold   <= rd_val;
          send_hold <= 1'b0;
          word_hold <= '0;
          case (act)
            ACT_READ: begin
              if ((off == OFF_DATA) && !rx_empty) begin
                rx_count <= rx_count - CNT_W'(1);
              end
            end
            ACT_WRITE: begin
              case (off)
                OFF_CR0: begin
                  ctrl_zero <= wdat;
                  word_mask <= size_mask(wdat[3:0]);
                end
                OFF_CR1:   ctrl_one <= wdat;
                OFF_DATA: begin
                  if (!tx_full) begin
                    tx_store[tx_head] <= wdat[15:0] & word_mask;
                    tx_head           <= ptr_inc(tx_head);
                    tx_count          <= tx_count + CNT_W'(1);
                  end
                end
                OFF_PRESC: prescale   <= wdat[7:0];
                OFF_IMSC:  irq_enable <= wdat;
                // clears rt and overrun only
                OFF_ICR:   raw_irq    <= raw_irq & ~{2'b0, wdat[1:0]};
                default: begin
                end
              endcase
            end
            ACT_REPLY: begin
              if (in_flight) begin
                in_flight <= 1'b0;
                if (!tx_empty) tx_count <= tx_count - CNT_W'(1);
                if (!rx_full) begin
                  rx_store[rx_head] <= sdat & word_mask;
                  rx_head           <= ptr_inc(rx_head);
                  rx_count          <= rx_count + CNT_W'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
        ST_PUMP: begin
          if (pump_go) begin
            if (ctrl_one[CR1_LOOP_BIT]) begin
              rx_store[rx_head] <= tx_store[tx_oldest] & word_mask;
              rx_head           <= ptr_inc(rx_head);
              rx_count          <= rx_count + CNT_W'(1);
              tx_count          <= tx_count - CNT_W'(1);
            end else begin
              // word stays counted in the tx fifo until its reply
              word_hold <= tx_store[tx_oldest];
              send_hold <= 1'b1;
              in_flight <= 1'b1;
            end
          end
        end
        ST_REFRESH: begin
          raw_irq   <= raw_next;
          irq_level <= |(raw_next & irq_enable[3:0]);
        end
        ST_FINISH: begin
          if (out_load) begin
            out_rd   <= rd_hold;
            out_irq  <= irq_level;
            out_send <= send_hold;
            out_word <= word_hold;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/spimf_checker.sv
// spimf_checker: port-level checks for spi_master_fifo_registers_core, bound to it
// depends on spimf_pkg
`timescale 1ns / 1ps

module spimf_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [spimf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input logic [1:0]                         s_axis_tuser,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [spimf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [0:0]                         m_axis_tuser
);
  import spimf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one request at a time through the sequencer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while sequencer busy");

  // no transfer word without a transfer start
  a_word_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[48:33] == 16'h0)
    else $error("send_word set without send_valid");

  // a bus write never reads anything back: its result appears only after exec and the output load
  a_reply_reply_no_send: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_WRITE |=> ##1 !m_axis_tvalid
      || $stable(m_axis_tdata))
    else $error("result produced too early after a write request");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid && s_axis_tready)
    else $error("not idle after reset");

endmodule

bind spi_master_fifo_registers_core spimf_checker u_spimf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
